FILE: rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types, constants and the sequence length decoder shared by the decoder
// files.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

  // Width of the character counters. Any value from 8 to 32 is supported.
  localparam int unsigned CountBits = 16;

  // Largest value the counters hold; a wider limit saturates to this.
  localparam logic [32:0] CountMax = (33'd1 << CountBits) - 33'd1;

  // Value XORed into every continuation byte.
  localparam logic [7:0] ContXor = 8'h80;

  // Sequence length codes taken from the lead byte's high nibble.
  localparam logic [2:0] SeqBad   = 3'd0;
  localparam logic [2:0] SeqOne   = 3'd1;
  localparam logic [2:0] SeqTwo   = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour  = 3'd4;

  // Status codes carried by each result item.
  localparam logic [2:0] StatusRunning  = 3'd0;
  localparam logic [2:0] StatusEnded    = 3'd1;
  localparam logic [2:0] StatusLimit    = 3'd2;
  localparam logic [2:0] StatusBadLead  = 3'd3;
  localparam logic [2:0] StatusZeroMid  = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_string;
    logic [15:0] char_limit;
  } u8dec_in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        char_valid;
    logic        is_final;
    logic [2:0]  status;
    logic [15:0] char_count;
  } u8dec_out_t;

  // Sequence length selected by the high nibble of a lead byte.
  function automatic logic [2:0] seq_len(input logic [3:0] nibble);
    logic [2:0] len;
    unique case (nibble) inside
      [4'h0:4'h7]:  len = SeqOne;
      [4'h8:4'hB]:  len = SeqBad;
      4'hC, 4'hD:   len = SeqTwo;
      4'hE:         len = SeqThree;
      default:      len = SeqFour;
    endcase
    return len;
  endfunction

endpackage : u8dec_pkg

`default_nettype wire

FILE: rtl/core/u8dec_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Holds the per-string decoding state and works out, for one byte, the next
// state and the result item that the byte causes, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dec_decode import u8dec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire u8dec_in_t  item_i,
  input  wire logic       fire_i,
  output      logic       res_valid_o,
  output      u8dec_out_t res_o
);

  logic                 stopped_q, stopped_d;
  logic [1:0]           pending_q, pending_d;
  logic [7:0]           lead_q, lead_d;
  logic [7:0]           second_q, second_d;
  logic [CountBits-1:0] left_q, left_d;
  logic [CountBits-1:0] done_q, done_d;

  logic                 start;
  logic [7:0]           b;
  logic [32:0]          lim_wide;
  logic [CountBits-1:0] lim_sat;
  logic                 stopped_e;
  logic [1:0]           pending_e;
  logic [7:0]           lead_e;
  logic [CountBits-1:0] left_e;
  logic [CountBits-1:0] done_e;
  logic [CountBits-1:0] left_dec;
  logic [2:0]           lead_len;
  logic [2:0]           held_len;
  logic [15:0]          unit_two;
  logic [15:0]          unit_three;
  logic                 emit_unit;
  logic [15:0]          unit;

  assign start    = item_i.start_of_string;
  assign b        = item_i.data_byte;
  assign lim_wide = 33'(item_i.char_limit);
  assign lim_sat  = (lim_wide > CountMax) ? CountBits'(CountMax) : CountBits'(lim_wide);

  // A start byte clears the state before the byte itself is decoded.
  assign stopped_e = start ? 1'b0 : stopped_q;
  assign pending_e = start ? 2'd0 : pending_q;
  assign lead_e    = start ? 8'd0 : lead_q;
  assign left_e    = start ? lim_sat : left_q;
  assign done_e    = start ? '0 : done_q;

  assign left_dec  = left_e - CountBits'(1);
  assign lead_len  = seq_len(b[7:4]);
  assign held_len  = seq_len(lead_e[7:4]);

  assign unit_two   = {5'd0, lead_e[4:0], 6'd0} | {8'd0, b ^ ContXor};
  assign unit_three = {lead_e[3:0], 12'd0} | {2'd0, second_q ^ ContXor, 6'd0}
                    | {8'd0, b ^ ContXor};

  always_comb begin
    stopped_d   = stopped_e;
    pending_d   = pending_e;
    lead_d      = lead_e;
    second_d    = start ? 8'd0 : second_q;
    left_d      = left_e;
    done_d      = done_e;
    res_valid_o = 1'b0;
    emit_unit   = 1'b0;
    unit        = 16'd0;
    res_o       = '0;

    if (start && (lim_sat == '0)) begin
      res_valid_o    = 1'b1;
      res_o.is_final = 1'b1;
      res_o.status   = StatusLimit;
    end else if (!stopped_e) begin
      if (pending_e == 2'd0) begin
        if (b == 8'd0) begin
          res_valid_o    = 1'b1;
          res_o.is_final = 1'b1;
          res_o.status   = StatusEnded;
        end else if (lead_len == SeqOne) begin
          emit_unit = 1'b1;
          unit      = {8'd0, b};
        end else if ((lead_len == SeqTwo) || (lead_len == SeqThree)) begin
          lead_d    = b;
          pending_d = (lead_len == SeqTwo) ? 2'd1 : 2'd2;
        end else begin
          res_valid_o    = 1'b1;
          res_o.is_final = 1'b1;
          res_o.status   = StatusBadLead;
        end
      end else begin
        if (b == 8'd0) begin
          res_valid_o    = 1'b1;
          res_o.is_final = 1'b1;
          res_o.status   = StatusZeroMid;
        end else if (held_len == SeqTwo) begin
          emit_unit = 1'b1;
          unit      = unit_two;
        end else if (pending_e == 2'd2) begin
          second_d  = b;
          pending_d = 2'd1;
        end else begin
          emit_unit = 1'b1;
          unit      = unit_three;
        end
      end
    end

    if (emit_unit) begin
      res_valid_o      = 1'b1;
      done_d           = done_e + CountBits'(1);
      left_d           = left_dec;
      pending_d        = 2'd0;
      res_o.code_unit  = unit;
      res_o.char_valid = 1'b1;
      res_o.is_final   = (left_dec == '0);
      res_o.status     = (left_dec == '0) ? StatusLimit : StatusRunning;
    end

    if (res_valid_o && res_o.is_final) begin
      stopped_d = 1'b1;
      pending_d = 2'd0;
    end

    res_o.char_count = 16'(33'(done_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b1;
      pending_q <= 2'd0;
      lead_q    <= 8'd0;
      second_q  <= 8'd0;
      left_q    <= '0;
      done_q    <= '0;
    end else if (fire_i) begin
      stopped_q <= stopped_d;
      pending_q <= pending_d;
      lead_q    <= lead_d;
      second_q  <= second_d;
      left_q    <= left_d;
      done_q    <= done_d;
    end
  end

  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.is_final |=> stopped_q && (pending_q == 2'd0))
    else $error("decoder did not stop after a final result");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two continuation bytes pending");

  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.char_valid |-> res_o.is_final && (res_o.status != StatusRunning))
    else $error("result without a character did not end the string");

  a_unit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.char_valid |=> done_q == $past(done_d))
    else $error("character count not advanced with a decoded unit");

endmodule : u8dec_decode

`default_nettype wire

FILE: rtl/core/utf8_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder
// Decodes UTF-8 into 16-bit code units, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// The decoder takes one UTF-8 byte per item and sustains one item per clock
// cycle while the output is not stalled: every byte goes into an input
// register, the decoding step is a short piece of logic, and the result lands
// in an output register. A byte marked as the start of a string clears the
// decoder and loads the character limit, which saturates at the counter
// width. One-, two- and three-byte sequences are recognised by the lead
// byte's high nibble; continuation bytes are not checked, they are simply
// XORed with 0x80 and ORed into place. A byte that completes a character
// yields one result item; lead bytes and the middle byte of a three-byte
// sequence yield none. Decoding stops, with a final result item, at a zero
// lead byte, at a bad lead byte, at a zero inside a sequence, or when the
// limit is used up; after that, bytes are ignored until the next start
// byte. The output register lets the next byte in while a result still
// waits to be taken, and the input is only stalled while the output is both
// full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder import u8dec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire u8dec_in_t  in_item_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      u8dec_out_t out_item_o
);

  logic       in_valid_q, in_valid_d;
  u8dec_in_t  in_item_q;
  logic       out_valid_q, out_valid_d;
  u8dec_out_t out_item_q;

  logic       advance;
  logic       fire;
  logic       in_accept;
  logic       res_valid;
  u8dec_out_t res;

  // The decode step may run whenever the output register is free or is being
  // emptied in this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // The output register holds its item while stalled and is otherwise
  // refilled by whatever the decode step produced this cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && res_valid;
    end
  end

  u8dec_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_item_q),
    .fire_i      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
    if (fire && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule : utf8_to_ucs2_decoder

`default_nettype wire

FILE: tb/sv/utf8_decode_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 decoder scoreboard
// Tracks the decoder's state from the bytes it accepts and checks each result
// item against the oldest predicted code unit.
// ----------------------------------------------------------------------------

package utf8_decode_sb_pkg;

  import u8dec_pkg::*;

  class ucs2_scoreboard;

    u8dec_out_t  units_due[$];
    int unsigned errors;
    int unsigned live_bytes;

    // Decoder state as seen from outside.
    bit          halted;
    logic [1:0]  bytes_owed;
    logic [7:0]  lead_byte;
    logic [7:0] mid_byte;
    logic [31:0] chars_left;
    logic [31:0] chars_done;

    function new();
      halted     = 1'b1;
      bytes_owed = '0;
      lead_byte  = '0;
      mid_byte   = '0;
      chars_left = '0;
      chars_done = '0;
      errors     = 0;
      live_bytes = 0;
    endfunction

    // Sequence kind selected by a lead byte.
    function logic [2:0] lead_kind(logic [7:0] b);
      case (b[7:4])
        4'hC, 4'hD: return SeqTwo;
        4'hE:       return SeqThree;
        4'hF:       return SeqFour;
        default:    return b[7] ? SeqBad : SeqOne;
      endcase
    endfunction

    function void post(logic [15:0] unit, logic valid, logic fin, logic [2:0] st);
      u8dec_out_t r;
      r.code_unit  = unit;
      r.char_valid = valid;
      r.is_final   = fin;
      r.status     = st;
      r.char_count = chars_done[15:0];
      if (fin) begin
        halted     = 1'b1;
        bytes_owed = '0;
      end
      units_due.push_back(r);
    endfunction

    function void post_char(logic [15:0] unit);
      logic [31:0] mask;
      mask       = CountMax[31:0];
      bytes_owed = '0;
      chars_done = (chars_done + 32'd1) & mask;
      chars_left = (chars_left - 32'd1) & mask;
      if (chars_left == 0) begin
        post(unit, 1'b1, 1'b1, StatusLimit);
      end else begin
        post(unit, 1'b1, 1'b0, StatusRunning);
      end
    endfunction

    // Advances the predicted state by one accepted byte.
    function void note_byte(u8dec_in_t it);
      logic [7:0]  b;
      logic [2:0]  kind;
      logic [15:0] unit;
      b = it.data_byte;
      live_bytes++;
      if (it.start_of_string) begin
        halted     = 1'b0;
        bytes_owed = '0;
        lead_byte  = '0;
        mid_byte   = '0;
        chars_done = '0;
        chars_left = (33'(it.char_limit) > CountMax) ? CountMax[31:0] : 32'(it.char_limit);
        if (chars_left == 0) begin
          post(16'h0000, 1'b0, 1'b1, StatusLimit);
          return;
        end
      end
      if (halted) return;
      if (bytes_owed == 0) begin
        kind = lead_kind(b);
        if (b == 8'h00) begin
          post(16'h0000, 1'b0, 1'b1, StatusEnded);
        end else if (kind == SeqOne) begin
          post_char({8'h00, b});
        end else if (kind == SeqTwo || kind == SeqThree) begin
          lead_byte  = b;
          bytes_owed = (kind == SeqTwo) ? 2'd1 : 2'd2;
        end else begin
          post(16'h0000, 1'b0, 1'b1, StatusBadLead);
        end
      end else if (b == 8'h00) begin
        post(16'h0000, 1'b0, 1'b1, StatusZeroMid);
      end else if (lead_kind(lead_byte) == SeqTwo) begin
        unit = (16'(lead_byte[4:0]) << 6) | 16'(b ^ ContXor);
        post_char(unit);
      end else if (bytes_owed == 2) begin
        mid_byte   = b;
        bytes_owed = 2'd1;
      end else begin
        unit = (16'(lead_byte[3:0]) << 12) | (16'(mid_byte ^ ContXor) << 6) | 16'(b ^ ContXor);
        post_char(unit);
      end
    endfunction

    function void check_unit(u8dec_out_t got);
      u8dec_out_t want;
      if (units_due.size() == 0) begin
        $error("unexpected result item: code_unit %0h, status %0d", got.code_unit, got.status);
        errors++;
        return;
      end
      want = units_due.pop_front();
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit: expected %0h, got %0h", want.code_unit, got.code_unit);
        errors++;
      end
      if (got.char_valid !== want.char_valid) begin
        $error("char_valid: expected %0b, got %0b", want.char_valid, got.char_valid);
        errors++;
      end
      if (got.is_final !== want.is_final) begin
        $error("is_final: expected %0b, got %0b", want.is_final, got.is_final);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.char_count !== want.char_count) begin
        $error("char_count: expected %0d, got %0d", want.char_count, got.char_count);
        errors++;
      end
    endfunction

  endclass

endpackage : utf8_decode_sb_pkg

FILE: tb/sv/utf8_to_ucs2_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder testbench
// Feeds directed and random UTF-8 strings through the decoder, with random
// idling on both sides and one long receiver hold-off, and checks every
// result item against a scoreboard that predicts the decoder's behaviour.
// ----------------------------------------------------------------------------

module utf8_to_ucs2_decoder_tb;

  import u8dec_pkg::*;
  import utf8_decode_sb_pkg::*;

  // Number of accepted bytes the random part aims for.
  localparam int unsigned RandomBytes   = 1450;
  // Length of the deliberate receiver hold-off.
  localparam int unsigned HoldOffCycles = 400;
  // Cycles allowed after the last expected item for stray results to show.
  localparam int unsigned DrainCycles   = 20;
  // Generous bound on the whole run; a correct run needs a small fraction.
  localparam int unsigned CycleLimit    = 1000000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  u8dec_in_t  in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  u8dec_out_t out_item_o;

  ucs2_scoreboard board;
  logic [7:0]     text_q[$];
  bit             no_gaps;
  bit             hold_off_req;
  int unsigned    cycle_count;

  utf8_to_ucs2_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Both handshakes are sampled at the clock edge, before any of that edge's
  // register updates land, so the view matches what the decoder itself saw.
  // Inputs are noted first; a result passes the input and output registers,
  // so it can never belong to a byte accepted at the same edge anyway.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_byte(in_item_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_unit(out_item_o);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver. It works in segments: quiet stretches with no stalls,
  // bursts of short stalls, and now and then a long stall. When the sender
  // side asks for a hold-off, the receiver stalls for a long fixed stretch,
  // counted here, so that the decoder fills up and has to stall its input.
  initial begin
    int unsigned seg_left;
    int unsigned r;
    seg_left    = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        seg_left = $urandom_range(20, 5);
      end else if (seg_left == 0) begin
        r = $urandom_range(99);
        if (r < 15) begin
          out_stall_i <= 1'b0;
          seg_left = $urandom_range(80, 20);
        end else if (r < 20) begin
          out_stall_i <= 1'b1;
          seg_left = $urandom_range(60, 15);
        end else if (r < 60) begin
          out_stall_i <= 1'b1;
          seg_left = $urandom_range(3, 0);
        end else begin
          out_stall_i <= 1'b0;
          seg_left = $urandom_range(4, 0);
        end
      end else begin
        seg_left--;
      end
    end
  end

  // Idle cycles before the next item: mostly none, sometimes a few, and
  // rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // A continuation byte: usually well formed, sometimes any value at all,
  // since the decoder does not check them.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 10) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Offers one item and returns at the edge where it is taken. The valid
  // stays high into the next item unless a gap follows.
  task automatic send_item(input u8dec_in_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sends the bytes in text_q as one string: the first byte carries the
  // start mark and the limit, the others carry a random limit that the
  // decoder must ignore.
  task automatic send_text(input logic [15:0] limit);
    u8dec_in_t it;
    foreach (text_q[i]) begin
      it.data_byte       = text_q[i];
      it.start_of_string = (i == 0);
      it.char_limit      = (i == 0) ? limit : 16'($urandom);
      send_item(it);
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned n_chars;
    int unsigned break_at;
    int unsigned target;
    int unsigned strings_sent;
    logic [15:0] limit;
    bit          broken;
    bit          abandon;

    in_valid_i   = 1'b0;
    in_item_i    = '0;
    rst_ni       = 1'b0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    cycle_count  = 0;
    strings_sent = 0;
    board        = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A limit of zero: the start byte is not decoded at all.
    text_q = {8'h41};
    send_text(16'h0000);
    // A string that is empty: it ends at its first byte.
    text_q = {8'h00};
    send_text(16'd5);
    // Largest one-, two- and three-byte forms, a three-byte form with
    // malformed continuations, then a normal end, under the largest limit.
    text_q = {8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'h7F, 8'h01, 8'hEF, 8'hBF, 8'hBF, 8'h00};
    send_text(16'hFFFF);
    // A stray continuation byte as lead, then a byte that must be ignored.
    text_q = {8'h80, 8'h41};
    send_text(16'd3);
    // A four-byte lead, which this decoder rejects.
    text_q = {8'hF0};
    send_text(16'd2);
    // Zero as the second byte, then as the third.
    text_q = {8'hC3, 8'h00};
    send_text(16'd4);
    text_q = {8'hE2, 8'h82, 8'h00};
    send_text(16'd4);
    // The limit is met on the last unit; the byte after it is ignored.
    text_q = {8'h41, 8'h42, 8'h43};
    send_text(16'd2);
    // A sequence left open, dropped by the next start; that string hits its
    // limit on a two-byte unit whose second byte is no continuation.
    text_q = {8'hE2};
    send_text(16'd3);
    text_q = {8'hC1, 8'h41};
    send_text(16'd1);

    target = board.live_bytes + RandomBytes;
    while (board.live_bytes < target) begin
      text_q.delete();
      if (strings_sent == 8) begin
        // Long hold-off on the result side while bytes keep coming with no
        // gaps, so that the decoder backs up and stalls its input.
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        repeat (40) text_q.push_back(8'($urandom_range(126, 32)));
        text_q.push_back(8'h00);
        send_text(16'hFFFF);
      end else begin
        r = $urandom_range(99);
        if (r < 10) limit = 16'h0000;
        else if (r < 20) limit = 16'hFFFF;
        else if (r < 35) limit = 16'($urandom);
        else limit = 16'($urandom_range(12, 1));
        no_gaps  = ($urandom_range(99) < 20);
        n_chars  = $urandom_range(14, 1);
        broken   = ($urandom_range(99) < 22);
        break_at = $urandom_range(n_chars - 1, 0);
        abandon  = 1'b0;
        for (int unsigned k = 0; k < n_chars && !abandon; k++) begin
          if (broken && k == break_at) begin
            case ($urandom_range(3))
              0: begin
                if ($urandom_range(1)) text_q.push_back({2'b10, 6'($urandom)});
                else text_q.push_back({4'hF, 4'($urandom)});
              end
              1: begin
                text_q.push_back({4'hE, 4'($urandom)});
                if ($urandom_range(1)) text_q.push_back(cont_byte());
                text_q.push_back(8'h00);
              end
              2: begin
                repeat ($urandom_range(4, 1)) text_q.push_back(8'($urandom));
              end
              default: begin
                // Open sequence cut off by the next string's start.
                text_q.push_back({3'b110, 5'($urandom)});
                abandon = 1'b1;
              end
            endcase
          end else begin
            r = $urandom_range(99);
            if (r < 40) begin
              text_q.push_back(8'($urandom_range(127, 1)));
            end else if (r < 70) begin
              text_q.push_back({3'b110, 5'($urandom)});
              text_q.push_back(cont_byte());
            end else begin
              text_q.push_back({4'hE, 4'($urandom)});
              text_q.push_back(cont_byte());
              text_q.push_back(cont_byte());
            end
          end
        end
        if (!abandon && $urandom_range(99) < 85) text_q.push_back(8'h00);
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom));
        end
        send_text(limit);
      end
      strings_sent++;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.units_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : utf8_to_ucs2_decoder_tb

FILE: utf8_to_ucs2_decoder.f
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_decode.sv
rtl/core/utf8_to_ucs2_decoder.sv
tb/sv/utf8_decode_sb_pkg.sv
tb/sv/utf8_to_ucs2_decoder_tb.sv
